>>> rtl/core/motion_burst_energy_scorer_defines.svh
// Assertion macros shared by the motion burst energy scorer RTL.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef MOTION_BURST_ENERGY_SCORER_DEFINES_SVH
`define MOTION_BURST_ENERGY_SCORER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define MBES_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define MBES_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mbes_pkg.sv
// Package for the motion burst energy scorer: constants, widths, state type.
// Used by motion_burst_energy_scorer; depends on nothing else.
`timescale 1ns / 1ps

package mbes_pkg;

  // Batch and capture lengths.
  localparam int unsigned BatchLen = 10;
  localparam int unsigned Windows  = 10;

  // Field and datapath widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 20;
  localparam int unsigned AbsW    = 20;
  localparam int unsigned EnergyW = 40;
  localparam int unsigned RootW   = 20;
  localparam int unsigned RemW    = 22;
  localparam int unsigned ScoreW  = 20;
  localparam int unsigned PunchW  = 16;
  localparam int unsigned TotalW  = 36;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CntW    = 6;
  localparam int unsigned PremW   = 17;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 80;

  // Sized forms of the constants used in compares.
  localparam logic [IdxW-1:0] BatchLenV = IdxW'(BatchLen);
  localparam logic [IdxW-1:0] WindowsV  = IdxW'(Windows);
  localparam logic [IdxW-1:0] IdleIdx   = 4'd15;
  localparam logic [4:0]      ScaleDiv  = 5'(BatchLen);

  // Last step of each serial loop.
  localparam logic [CntW-1:0] SqLast   = CntW'(AbsW - 1);
  localparam logic [CntW-1:0] RootLast = CntW'(RootW - 1);
  localparam logic [CntW-1:0] AvgLast  = CntW'(TotalW - 1);

  // Axis select codes.
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  // Operation codes carried in tuser.
  localparam logic OpTap    = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_ROOT,
    ST_SCALE,
    ST_CAPT,
    ST_SCORE,
    ST_AVG,
    ST_AVG_END,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic emit;
  } ctrl_t;

endpackage

>>> rtl/core/motion_burst_energy_scorer.sv
// A tap or a sample inside a batch goes from the input through ST_EMIT to the output register;
// a sample that closes a batch first runs three serial squares, a 20-step root and a 20-step
// divide by the batch length, and when it also ends a capture, a 36-step serial divide for the
// average. Throughput: one item in flight; the next transfer can be taken the cycle after the
// result enters the output register. Reset (rst_ni low, asynchronous) clears the control state
// and scores at once; the serial shift registers and the output data are not reset.
// Top level of the motion burst energy scorer; depends on mbes_pkg and the defines header.
`timescale 1ns / 1ps
`include "motion_burst_energy_scorer_defines.svh"

module motion_burst_energy_scorer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [47:0]  s_axis_tdata,
  // operation [0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // last_score [19:0], best_score [39:20], average_score [59:40],
  // punch_count [75:60], zero [79:76]
  output logic [79:0]  m_axis_tdata,
  // score_ready [0]
  output logic [0:0]   m_axis_tuser
);

  mbes_pkg::state_e state_q, state_d;
  mbes_pkg::ctrl_t  ctrl;

  logic        [mbes_pkg::IdxW-1:0]    batch_pos_q;
  logic        [mbes_pkg::SumW-1:0]    sum_x_q, sum_y_q, sum_z_q;
  logic        [mbes_pkg::IdxW-1:0]    window_q;
  logic        [mbes_pkg::ScoreW-1:0]  capture_q, best_q, last_q, avg_q;
  logic        [mbes_pkg::PunchW-1:0]  punches_q;
  logic        [mbes_pkg::TotalW-1:0]  total_q;
  logic        [mbes_pkg::EnergyW-1:0] work_q, mcand_q;
  logic        [mbes_pkg::AbsW-1:0]    mplier_q;
  logic        [1:0]                   axis_q;
  logic        [mbes_pkg::CntW-1:0]    cnt_q;
  logic        [mbes_pkg::RemW-1:0]    rem_q;
  logic        [mbes_pkg::RootW-1:0]   root_q;
  logic        [mbes_pkg::PremW-1:0]   prem_q;
  logic                                flag_q;
  logic                                out_valid_q;
  logic        [mbes_pkg::OutDataW-1:0] out_data_q;
  logic                                out_user_q;

  // Sign-extended sample fields and the new batch sums.
  logic [mbes_pkg::SumW-1:0] ext_x, ext_y, ext_z;
  logic [mbes_pkg::SumW-1:0] sum_x_d, sum_y_d, sum_z_d;
  logic [mbes_pkg::IdxW-1:0] batch_pos_d;
  logic                      batch_end;

  assign ext_x = {{(mbes_pkg::SumW - mbes_pkg::SampleW){s_axis_tdata[15]}},
                  s_axis_tdata[15:0]};
  assign ext_y = {{(mbes_pkg::SumW - mbes_pkg::SampleW){s_axis_tdata[31]}},
                  s_axis_tdata[31:16]};
  assign ext_z = {{(mbes_pkg::SumW - mbes_pkg::SampleW){s_axis_tdata[47]}},
                  s_axis_tdata[47:32]};
  assign sum_x_d     = sum_x_q + ext_x;
  assign sum_y_d     = sum_y_q + ext_y;
  assign sum_z_d     = sum_z_q + ext_z;
  assign batch_pos_d = batch_pos_q + 1'b1;
  assign batch_end   = (batch_pos_d == mbes_pkg::BatchLenV);

  // Magnitude of the batch sum that is squared next.
  logic [mbes_pkg::SumW-1:0] sel_sum;
  logic [mbes_pkg::AbsW-1:0] abs_val;

  always_comb begin
    case (axis_q)
      mbes_pkg::AxisX: sel_sum = sum_x_q;
      mbes_pkg::AxisY: sel_sum = sum_y_q;
      default:         sel_sum = sum_z_q;
    endcase
    abs_val = sel_sum[mbes_pkg::SumW-1] ? (~sel_sum + 1'b1) : sel_sum;
  end

  // One step of the digit-by-digit square root: two radicand bits per cycle.
  logic [mbes_pkg::RemW:0] rem_shift, root_trial, rem_sub;
  logic                    root_ge;

  assign rem_shift  = {rem_q[mbes_pkg::RemW-2:0],
                       work_q[mbes_pkg::EnergyW-1:mbes_pkg::EnergyW-2]};
  assign root_trial = {1'b0, root_q, 2'b01};
  assign root_ge    = (rem_shift >= root_trial);
  assign rem_sub    = rem_shift - root_trial;

  // One step of the restoring divide by the batch length.
  logic [4:0] scale_pr;
  logic       scale_ge;
  logic [4:0] scale_sub;

  assign scale_pr  = {prem_q[3:0], root_q[mbes_pkg::RootW-1]};
  assign scale_ge  = (scale_pr >= mbes_pkg::ScaleDiv);
  assign scale_sub = scale_pr - mbes_pkg::ScaleDiv;

  // One step of the restoring divide of the total by the punch count.
  logic [mbes_pkg::PremW-1:0] avg_pr, avg_sub;
  logic                       avg_ge;

  assign avg_pr  = {prem_q[mbes_pkg::PremW-2:0], work_q[mbes_pkg::TotalW-1]};
  assign avg_ge  = (avg_pr >= {1'b0, punches_q});
  assign avg_sub = avg_pr - {1'b0, punches_q};

  // Capture and total sums, both saturating.
  logic [mbes_pkg::ScoreW:0]   cap_sum;
  logic [mbes_pkg::ScoreW-1:0] cap_sat;
  logic [mbes_pkg::TotalW:0]   tot_sum;
  logic [mbes_pkg::TotalW-1:0] tot_sat;
  logic [mbes_pkg::IdxW-1:0]   window_d;

  assign cap_sum  = {1'b0, capture_q} + {1'b0, root_q};
  assign cap_sat  = cap_sum[mbes_pkg::ScoreW] ? '1 : cap_sum[mbes_pkg::ScoreW-1:0];
  assign tot_sum  = {1'b0, total_q} + (mbes_pkg::TotalW + 1)'(capture_q);
  assign tot_sat  = tot_sum[mbes_pkg::TotalW] ? '1 : tot_sum[mbes_pkg::TotalW-1:0];
  assign window_d = window_q + 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbes_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0] == mbes_pkg::OpSample && batch_end) begin
            state_d = mbes_pkg::ST_LOAD;
          end else begin
            state_d = mbes_pkg::ST_EMIT;
          end
        end
      end
      mbes_pkg::ST_LOAD: state_d = mbes_pkg::ST_SQ;
      mbes_pkg::ST_SQ: begin
        if (cnt_q == mbes_pkg::SqLast) begin
          state_d = (axis_q == mbes_pkg::AxisZ) ? mbes_pkg::ST_ROOT : mbes_pkg::ST_LOAD;
        end
      end
      mbes_pkg::ST_ROOT: begin
        if (cnt_q == mbes_pkg::RootLast) state_d = mbes_pkg::ST_SCALE;
      end
      mbes_pkg::ST_SCALE: begin
        if (cnt_q == mbes_pkg::RootLast) state_d = mbes_pkg::ST_CAPT;
      end
      mbes_pkg::ST_CAPT: begin
        if (window_q < mbes_pkg::WindowsV && window_d == mbes_pkg::WindowsV) begin
          state_d = mbes_pkg::ST_SCORE;
        end else begin
          state_d = mbes_pkg::ST_EMIT;
        end
      end
      mbes_pkg::ST_SCORE: state_d = mbes_pkg::ST_AVG;
      mbes_pkg::ST_AVG: begin
        if (cnt_q == mbes_pkg::AvgLast) state_d = mbes_pkg::ST_AVG_END;
      end
      mbes_pkg::ST_AVG_END: state_d = mbes_pkg::ST_EMIT;
      mbes_pkg::ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) state_d = mbes_pkg::ST_IDLE;
      end
      default: state_d = mbes_pkg::ST_IDLE;
    endcase
  end

  // Handshake and strobe outputs of the sequencer.
  always_comb begin
    s_axis_tready = (state_q == mbes_pkg::ST_IDLE);
    ctrl.accept   = (state_q == mbes_pkg::ST_IDLE) && s_axis_tvalid;
    ctrl.emit     = (state_q == mbes_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbes_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Block state and serial datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_pos_q <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      window_q    <= mbes_pkg::IdleIdx;
      capture_q   <= '0;
      punches_q   <= '0;
      best_q      <= '0;
      total_q     <= '0;
      last_q      <= '0;
      avg_q       <= '0;
      flag_q      <= 1'b0;
      axis_q      <= mbes_pkg::AxisX;
      cnt_q       <= '0;
    end else begin
      case (state_q)
        mbes_pkg::ST_IDLE: begin
          if (ctrl.accept) begin
            flag_q <= 1'b0;
            if (s_axis_tuser[0] == mbes_pkg::OpTap) begin
              if (punches_q != '1) punches_q <= punches_q + 1'b1;
              window_q  <= '0;
              capture_q <= '0;
            end else begin
              sum_x_q <= sum_x_d;
              sum_y_q <= sum_y_d;
              sum_z_q <= sum_z_d;
              if (batch_end) begin
                batch_pos_q <= '0;
                axis_q      <= mbes_pkg::AxisX;
              end else begin
                batch_pos_q <= batch_pos_d;
              end
            end
          end
        end
        mbes_pkg::ST_LOAD: cnt_q <= '0;
        mbes_pkg::ST_SQ: begin
          if (cnt_q == mbes_pkg::SqLast) begin
            cnt_q <= '0;
            if (axis_q == mbes_pkg::AxisZ) begin
              sum_x_q <= '0;
              sum_y_q <= '0;
              sum_z_q <= '0;
            end else begin
              axis_q <= axis_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        mbes_pkg::ST_ROOT, mbes_pkg::ST_SCALE: begin
          cnt_q <= (cnt_q == mbes_pkg::RootLast) ? '0 : cnt_q + 1'b1;
        end
        mbes_pkg::ST_CAPT: begin
          if (window_q < mbes_pkg::WindowsV) begin
            capture_q <= cap_sat;
            // The last window of a capture returns the index straight to idle.
            window_q  <= (window_d == mbes_pkg::WindowsV) ? mbes_pkg::IdleIdx : window_d;
          end
        end
        mbes_pkg::ST_SCORE: begin
          last_q   <= capture_q;
          if (capture_q > best_q) best_q <= capture_q;
          total_q  <= tot_sat;
          window_q <= mbes_pkg::IdleIdx;
          flag_q   <= 1'b1;
          cnt_q    <= '0;
        end
        mbes_pkg::ST_AVG: cnt_q <= cnt_q + 1'b1;
        mbes_pkg::ST_AVG_END: begin
          cnt_q <= '0;
          if (punches_q == '0) begin
            avg_q <= '0;
          end else if (|work_q[mbes_pkg::TotalW-1:mbes_pkg::ScoreW]) begin
            avg_q <= '1;
          end else begin
            avg_q <= work_q[mbes_pkg::ScoreW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Shift registers of the serial units; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mbes_pkg::ST_IDLE: begin
        work_q <= '0;
      end
      mbes_pkg::ST_LOAD: begin
        mcand_q  <= {{(mbes_pkg::EnergyW - mbes_pkg::AbsW){1'b0}}, abs_val};
        mplier_q <= abs_val;
      end
      mbes_pkg::ST_SQ: begin
        // Shift-and-add square: one multiplier bit per cycle.
        if (mplier_q[0]) work_q <= work_q + mcand_q;
        mcand_q  <= {mcand_q[mbes_pkg::EnergyW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[mbes_pkg::AbsW-1:1]};
        rem_q    <= '0;
        root_q   <= '0;
      end
      mbes_pkg::ST_ROOT: begin
        work_q <= {work_q[mbes_pkg::EnergyW-3:0], 2'b00};
        rem_q  <= root_ge ? rem_sub[mbes_pkg::RemW-1:0] : rem_shift[mbes_pkg::RemW-1:0];
        root_q <= {root_q[mbes_pkg::RootW-2:0], root_ge};
        prem_q <= '0;
      end
      mbes_pkg::ST_SCALE: begin
        prem_q <= {{(mbes_pkg::PremW - 4){1'b0}},
                   (scale_ge ? scale_sub[3:0] : scale_pr[3:0])};
        root_q <= {root_q[mbes_pkg::RootW-2:0], scale_ge};
      end
      mbes_pkg::ST_SCORE: begin
        work_q <= {{(mbes_pkg::EnergyW - mbes_pkg::TotalW){1'b0}}, tot_sat};
        prem_q <= '0;
      end
      mbes_pkg::ST_AVG: begin
        // Quotient bits shift in where dividend bits shift out.
        work_q <= {{(mbes_pkg::EnergyW - mbes_pkg::TotalW){1'b0}},
                   work_q[mbes_pkg::TotalW-2:0], avg_ge};
        prem_q <= avg_ge ? avg_sub : avg_pr;
      end
      default: ;
    endcase
  end

  // Output register: holds one result until the sink takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= {4'b0000, punches_q, avg_q, best_q, last_q};
      out_user_q <= flag_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

  // Checks on the block's own state.
  `MBES_ASSERT_ALWAYS(a_batch_pos_range, batch_pos_q < mbes_pkg::BatchLenV,
                      "batch position reached the batch length")
  `MBES_ASSERT_ALWAYS(a_window_range,
                      (window_q == mbes_pkg::IdleIdx) || (window_q < mbes_pkg::WindowsV),
                      "window index outside capture range")
  `MBES_ASSERT_ALWAYS(a_best_covers_last, best_q >= last_q,
                      "best score below last score")
  `MBES_ASSERT_NEXT(a_punches_monotonic, 1'b1, punches_q >= $past(punches_q),
                    "punch count decreased")
  `MBES_ASSERT_NEXT(a_score_flags, state_q == mbes_pkg::ST_SCORE,
                    flag_q && (window_q == mbes_pkg::IdleIdx),
                    "capture end did not flag a score")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for motion_burst_energy_scorer. It drives tap and sample transfers,
// predicts every result with a behavioral model of the scorer, and checks each output transfer.
// Depends on mbes_pkg and the motion_burst_energy_scorer RTL.
`timescale 1ns / 1ps

module tb_top;

  // Widths taken from the package.
  localparam int unsigned ScoreW   = mbes_pkg::ScoreW;
  localparam int unsigned PunchW   = mbes_pkg::PunchW;
  localparam int unsigned SumW     = mbes_pkg::SumW;
  localparam int unsigned IdxW     = mbes_pkg::IdxW;
  localparam int unsigned TotalW   = mbes_pkg::TotalW;
  localparam int unsigned SampleW  = mbes_pkg::SampleW;
  localparam int unsigned InDataW  = mbes_pkg::InDataW;
  localparam int unsigned OutDataW = mbes_pkg::OutDataW;

  // One expected output transfer.
  typedef struct packed {
    logic              ready_f;
    logic [ScoreW-1:0] last_sc;
    logic [ScoreW-1:0] best_sc;
    logic [ScoreW-1:0] avg_sc;
    logic [PunchW-1:0] punch_n;
  } score_t;

  // Clock, reset and the driven side of both streams.
  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                tx_valid = 1'b0;
  logic [InDataW-1:0]  tx_data  = '0;
  logic [0:0]          tx_user  = '0;
  logic                rx_ready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;

  // Scorer state as the testbench expects it to be.
  logic [3:0]             bat_pos;
  logic signed [SumW-1:0] sum_ax, sum_ay, sum_az;
  logic [IdxW-1:0]        win_idx;
  logic [ScoreW-1:0]      cap_sum, last_sc_q, best_sc_q, avg_sc_q;
  logic [PunchW-1:0]      punch_q;
  logic [TotalW-1:0]      total_q;
  score_t                 score_queue[$];

  // Run control shared by the test tasks and the receiver.
  bit          tx_gaps     = 1'b1;
  bit          rx_stalls   = 1'b1;
  int unsigned rx_hold_len = 0;
  int unsigned err_count   = 0;
  int unsigned items_sent  = 0;
  int unsigned results_seen = 0;

  motion_burst_energy_scorer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (tx_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (tx_data),
    .s_axis_tuser  (tx_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Floor of the square root, built up one result bit at a time from the top.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
    logic [31:0] r;
    logic [31:0] t;
    int          b;
    r = '0;
    for (b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (({32'd0, t} * {32'd0, t}) <= n) r = t;
    end
    return r;
  endfunction

  function automatic void clear_scorer();
    bat_pos   = '0;
    sum_ax    = '0;
    sum_ay    = '0;
    sum_az    = '0;
    win_idx   = mbes_pkg::IdleIdx;
    cap_sum   = '0;
    punch_q   = '0;
    best_sc_q = '0;
    total_q   = '0;
    last_sc_q = '0;
    avg_sc_q  = '0;
  endfunction

  // Advance the expected state by one accepted item and queue the result it produces.
  function automatic void predict_score(input logic op,
                                        input logic [SampleW-1:0] ax, ay, az);
    score_t            res;
    longint            sxl, syl, szl;
    logic [63:0]       energy;
    logic [ScoreW-1:0] mag;
    logic [ScoreW:0]   cap_next;
    logic [TotalW:0]   tot_next;
    logic [TotalW-1:0] avg_full;
    res.ready_f = 1'b0;
    if (op == mbes_pkg::OpTap) begin
      // A tap counts a punch and (re)starts the capture; the batch is left alone.
      if (punch_q != '1) punch_q++;
      win_idx = '0;
      cap_sum = '0;
    end else begin
      sum_ax = sum_ax + $signed(ax);
      sum_ay = sum_ay + $signed(ay);
      sum_az = sum_az + $signed(az);
      bat_pos++;
      if (bat_pos >= mbes_pkg::BatchLen) begin
        sxl    = sum_ax;
        syl    = sum_ay;
        szl    = sum_az;
        energy = sxl * sxl + syl * syl + szl * szl;
        mag    = ScoreW'(floor_sqrt(energy) / mbes_pkg::BatchLen);
        bat_pos = '0;
        sum_ax  = '0;
        sum_ay  = '0;
        sum_az  = '0;
        // Magnitudes only count while a capture is running.
        if (win_idx < mbes_pkg::Windows) begin
          cap_next = {1'b0, cap_sum} + mag;
          cap_sum  = cap_next[ScoreW] ? '1 : cap_next[ScoreW-1:0];
          win_idx++;
          if (win_idx >= mbes_pkg::Windows) begin
            last_sc_q = cap_sum;
            if (cap_sum > best_sc_q) best_sc_q = cap_sum;
            tot_next = {1'b0, total_q} + cap_sum;
            total_q  = tot_next[TotalW] ? '1 : tot_next[TotalW-1:0];
            avg_full = (punch_q != 0) ? total_q / punch_q : '0;
            avg_sc_q = ((avg_full >> ScoreW) != 0) ? '1 : avg_full[ScoreW-1:0];
            win_idx  = mbes_pkg::IdleIdx;
            res.ready_f = 1'b1;
          end
        end
      end
    end
    res.last_sc = last_sc_q;
    res.best_sc = best_sc_q;
    res.avg_sc  = avg_sc_q;
    res.punch_n = punch_q;
    score_queue.push_back(res);
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    $display("tb_top: mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [ScoreW-1:0] got,
                             input logic [ScoreW-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s got %0h expected %0h", results_seen, name, got,
                             want));
  endtask

  // Compare one output transfer with the oldest expected result.
  task automatic check_score();
    score_t want;
    results_seen++;
    if (score_queue.size() == 0) begin
      report_error($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = score_queue.pop_front();
    check_field("score_ready", ScoreW'(m_axis_tuser[0]), ScoreW'(want.ready_f));
    check_field("last_score", m_axis_tdata[19:0], want.last_sc);
    check_field("best_score", m_axis_tdata[39:20], want.best_sc);
    check_field("average_score", m_axis_tdata[59:40], want.avg_sc);
    check_field("punch_count", ScoreW'(m_axis_tdata[75:60]), ScoreW'(want.punch_n));
    check_field("padding", ScoreW'(m_axis_tdata[79:76]), '0);
  endtask

  // Receiver: checks each transfer, stalls at random, and honors a requested hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && rx_ready) check_score();
      if (rx_hold_len != 0) begin
        rx_hold_len = rx_hold_len - 1;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= !rx_stalls || ($urandom_range(99) >= 34);
      end
    end
  end

  // Offer one item, optionally after a random gap, and return once it is transferred.
  task automatic send_item(input logic op, input logic [SampleW-1:0] ax, ay, az);
    if (tx_gaps) begin
      while ($urandom_range(99) < 34) begin
        tx_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    tx_valid <= 1'b1;
    tx_user  <= op;
    tx_data  <= {az, ay, ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_score(op, ax, ay, az);
    items_sent++;
  endtask

  // One axis value: mostly full range, with small, extreme and mid-sized values mixed in.
  function automatic logic [SampleW-1:0] rand_axis(input bit quiet);
    int unsigned pick;
    pick = $urandom_range(99);
    if (quiet || (pick >= 55 && pick < 70)) return SampleW'($urandom_range(6) - 3);
    if (pick < 55) return SampleW'($urandom);
    if (pick < 85) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return SampleW'($urandom_range(2000) - 1000);
  endfunction

  // Tap data is random since the block must ignore it.
  task automatic send_tap();
    send_item(mbes_pkg::OpTap, SampleW'($urandom), SampleW'($urandom), SampleW'($urandom));
  endtask

  task automatic send_sample(input bit quiet);
    send_item(mbes_pkg::OpSample, rand_axis(quiet), rand_axis(quiet), rand_axis(quiet));
  endtask

  // Stop offering and wait until every expected result has been checked.
  task automatic drain_results();
    tx_valid <= 1'b0;
    do @(posedge clk_i); while (score_queue.size() != 0);
  endtask

  // Largest and smallest batch sums, with taps landing inside a batch and inside a capture.
  task automatic test_directed_extremes();
    send_tap();
    repeat (4) send_item(mbes_pkg::OpSample, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_tap();
    repeat (6) send_item(mbes_pkg::OpSample, 16'h7FFF, 16'h8000, 16'h7FFF);
    repeat (10) send_item(mbes_pkg::OpSample, 16'h8000, 16'h8000, 16'h8000);
    drain_results();
  endtask

  // A whole capture of zero and tiny batches: roots of zero and of small sums.
  task automatic test_quiet_capture();
    int unsigned i;
    send_tap();
    for (i = 0; i < mbes_pkg::Windows * mbes_pkg::BatchLen; i++) begin
      if (i < 3 * mbes_pkg::BatchLen) send_item(mbes_pkg::OpSample, '0, '0, '0);
      else send_sample(1'b1);
    end
    drain_results();
  endtask

  // Mostly complete captures with random content, plus idle samples and cut-short captures.
  task automatic test_random_bursts();
    int unsigned start, kind, run_len, n;
    bit          quiet;
    start = items_sent;
    while (items_sent - start < 1200) begin
      // A stretch in the middle runs with neither side idling.
      tx_gaps   = (items_sent - start < 500) || (items_sent - start >= 800);
      rx_stalls = tx_gaps;
      kind  = $urandom_range(99);
      quiet = ($urandom_range(4) == 0);
      if (kind < 70) begin
        // Enough samples to finish the capture; a rare extra tap restarts it.
        send_tap();
        run_len = mbes_pkg::Windows * mbes_pkg::BatchLen +
                  $urandom_range(mbes_pkg::BatchLen + 5);
        for (n = 0; n < run_len; n++) begin
          if ($urandom_range(299) == 0) send_tap();
          else send_sample(quiet);
        end
      end else if (kind < 85) begin
        run_len = $urandom_range(3 * mbes_pkg::BatchLen, 1);
        repeat (run_len) send_sample(quiet);
      end else begin
        send_tap();
        run_len = $urandom_range((mbes_pkg::Windows - 1) * mbes_pkg::BatchLen,
                                 mbes_pkg::BatchLen);
        repeat (run_len) send_sample(quiet);
        send_tap();
      end
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    drain_results();
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_output_hold();
    tx_gaps     = 1'b0;
    rx_hold_len = 300;
    repeat (40) send_sample(1'b0);
    tx_gaps = 1'b1;
    drain_results();
  endtask

  initial begin
    clear_scorer();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_quiet_capture();
    test_random_bursts();
    test_output_hold();
    drain_results();
    // Wait longer than a capture end takes, so that stray results have time to show up.
    repeat (200) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
